>>> rtl/core/cpts_pkg.sv
// ----------------------------------------------------------------------------
// cpts_pkg
// Shared types and codes for the counter/priority task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package cpts_pkg;

    // Input action codes
    localparam logic ACT_TICK = 1'b0;
    localparam logic ACT_LOAD = 1'b1;

    typedef struct packed {
        logic        action;
        logic [2:0]  task_index;
        logic [15:0] counter_value;
        logic [15:0] priority_value;
    } t_in;

    typedef struct packed {
        logic [2:0] current_task;
        logic       switched;
        logic       refilled;
        logic       no_runnable;
    } t_out;

    // Broadcast command from the controller to every cell
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_DEC,
        CMD_REFILL
    } t_cmd_op;

    // Control part of the scan wave passed from cell to cell
    typedef struct packed {
        logic valid;   // wave present at this position
        logic have;    // a nonzero counter has been seen
        logic run_nz;  // running task seen with a nonzero counter
    } t_wave_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESCAN,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

>>> rtl/core/cpts_cell.sv
// ----------------------------------------------------------------------------
// cpts_cell
// One task slot: counter and priority, plus one stage of the scan wave.
// ----------------------------------------------------------------------------
`default_nettype none

module cpts_cell
    import cpts_pkg::*;
#(
    parameter int IW       = 3,
    parameter int CW       = 16,
    parameter int CELL_IDX = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cmd_op       i_cmd_op,
    input  wire logic [IW-1:0] i_cmd_idx,
    input  wire logic [CW-1:0] i_cmd_cnt,
    input  wire logic [CW-1:0] i_cmd_pri,
    input  wire logic [IW-1:0] i_running,
    input  wire t_wave_ctl     i_wave_ctl,
    input  wire logic [CW-1:0] i_wave_val,
    input  wire logic [IW-1:0] i_wave_idx,
    output t_wave_ctl          o_wave_ctl,
    output logic [CW-1:0]      o_wave_val,
    output logic [IW-1:0]      o_wave_idx
);

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_pri;
    t_wave_ctl     r_wave_ctl;
    logic [CW-1:0] r_wave_val;
    logic [IW-1:0] r_wave_idx;

    logic sel;
    logic cnt_nz;
    logic take;

    assign sel    = (i_cmd_idx == MY_IDX);
    assign cnt_nz = (r_cnt != '0);
    // >= gives ties to the higher index, as the wave runs upward
    assign take   = i_wave_ctl.valid && cnt_nz &&
                    (!i_wave_ctl.have || (r_cnt >= i_wave_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_pri <= '0;
        end else begin
            case (i_cmd_op)
                CMD_LOAD: begin
                    if (sel) begin
                        r_cnt <= i_cmd_cnt;
                        r_pri <= i_cmd_pri;
                    end
                end
                CMD_DEC: begin
                    if (sel) begin
                        r_cnt <= r_cnt - CW'(1);
                    end
                end
                CMD_REFILL: begin
                    r_cnt <= r_pri;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_ctl <= '0;
        end else begin
            r_wave_ctl.valid  <= i_wave_ctl.valid;
            r_wave_ctl.have   <= i_wave_ctl.have | take;
            r_wave_ctl.run_nz <= i_wave_ctl.run_nz |
                                 (i_wave_ctl.valid && cnt_nz && (i_running == MY_IDX));
        end
    end

    always_ff @(posedge i_clk) begin
        r_wave_val <= take ? r_cnt  : i_wave_val;
        r_wave_idx <= take ? MY_IDX : i_wave_idx;
    end

    assign o_wave_ctl = r_wave_ctl;
    assign o_wave_val = r_wave_val;
    assign o_wave_idx = r_wave_idx;

endmodule

`default_nettype wire

>>> rtl/core/counter_priority_task_scheduler_top.sv
// ----------------------------------------------------------------------------
// counter_priority_task_scheduler_top
// Counter-based task pick with refill from priorities, built as a cell chain.
// ----------------------------------------------------------------------------
// One request in gives one request out. A load request is accepted, and then
// its result is placed in the output register. A timer tick sends a scan
// wave through the row of NUM_TASKS-1 task cells, one cell per cycle; when
// every counter is zero the counters are refilled from the priorities and
// the wave runs a second time. A scan lasts as long as the wave takes to
// cross the cell chain. The input is stalled while a request is in work; a
// finished result waits in the output register while the next request is
// taken.
// Task 0 is the idle task: it has no cell and is never picked.
// ----------------------------------------------------------------------------
`default_nettype none

module counter_priority_task_scheduler_top
    import cpts_pkg::*;
#(
    parameter int NUM_TASKS   = 8,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    localparam int IW = $clog2(NUM_TASKS);
    localparam int CW = COUNT_WIDTH;

    // Controller state
    t_state        r_state, n_state;
    logic [IW-1:0] r_running, n_running;
    logic          r_pass2, n_pass2;     // second scan, after a refill
    t_out          r_res, n_res;         // result being built
    t_out          r_out;
    logic          r_out_valid, n_out_valid;

    // Broadcast command
    t_cmd_op       cmd_op;
    logic [IW-1:0] cmd_idx;
    logic [CW-1:0] cmd_cnt;
    logic [CW-1:0] cmd_pri;

    // Scan wave chain: position 0 is the injection point, position i is
    // the output of cell i.
    t_wave_ctl     w_ctl [NUM_TASKS];
    logic [CW-1:0] w_val [NUM_TASKS];
    logic [IW-1:0] w_idx [NUM_TASKS];

    logic          in_accept;
    logic          out_free;
    logic          inject;
    logic          load_ok;
    t_wave_ctl     last_ctl;
    logic [IW-1:0] last_idx;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign load_ok   = (i_in_data.task_index != 3'd0) &&
                       (32'(i_in_data.task_index) < 32'(NUM_TASKS));

    assign last_ctl = w_ctl[NUM_TASKS-1];
    assign last_idx = w_idx[NUM_TASKS-1];

    // A fresh wave enters cell 1 on a tick and again after a refill
    assign inject       = (in_accept && (i_in_data.action == ACT_TICK)) ||
                          (r_state == ST_RESCAN);
    assign w_ctl[0].valid  = inject;
    assign w_ctl[0].have   = 1'b0;
    assign w_ctl[0].run_nz = 1'b0;
    assign w_val[0]        = '0;
    assign w_idx[0]        = '0;

    for (genvar gi = 1; gi < NUM_TASKS; gi++) begin : g_cell
        cpts_cell #(
            .IW       (IW),
            .CW       (CW),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd_op   (cmd_op),
            .i_cmd_idx  (cmd_idx),
            .i_cmd_cnt  (cmd_cnt),
            .i_cmd_pri  (cmd_pri),
            .i_running  (r_running),
            .i_wave_ctl (w_ctl[gi-1]),
            .i_wave_val (w_val[gi-1]),
            .i_wave_idx (w_idx[gi-1]),
            .o_wave_ctl (w_ctl[gi]),
            .o_wave_val (w_val[gi]),
            .o_wave_idx (w_idx[gi])
        );
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_in_data.action == ACT_LOAD) ? ST_EMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (last_ctl.valid) begin
                    if (!r_pass2 && last_ctl.run_nz) begin
                        n_state = ST_EMIT;
                    end else if (last_ctl.have) begin
                        n_state = ST_EMIT;
                    end else if (!r_pass2) begin
                        n_state = ST_RESCAN;
                    end else begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_RESCAN: begin
                n_state = ST_SCAN;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs, commands and register updates
    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        cmd_op      = CMD_NONE;
        cmd_idx     = r_running;
        cmd_cnt     = CW'(i_in_data.counter_value);
        cmd_pri     = CW'(i_in_data.priority_value);
        n_running   = r_running;
        n_pass2     = r_pass2;
        n_res       = r_res;
        n_out_valid = r_out_valid;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                n_pass2 = 1'b0;
                if (in_accept && (i_in_data.action == ACT_LOAD)) begin
                    if (load_ok) begin
                        cmd_op  = CMD_LOAD;
                        cmd_idx = IW'(i_in_data.task_index);
                    end
                    n_res = '{current_task: 3'(r_running), switched: 1'b0,
                              refilled: 1'b0, no_runnable: 1'b0};
                end
            end
            ST_SCAN: begin
                if (last_ctl.valid) begin
                    if (!r_pass2 && last_ctl.run_nz) begin
                        // running task still has time left
                        cmd_op  = CMD_DEC;
                        cmd_idx = r_running;
                        n_res   = '{current_task: 3'(r_running), switched: 1'b0,
                                    refilled: 1'b0, no_runnable: 1'b0};
                    end else if (last_ctl.have) begin
                        if (last_idx != r_running) begin
                            cmd_op    = CMD_DEC;
                            cmd_idx   = last_idx;
                            n_running = last_idx;
                            n_res     = '{current_task: 3'(last_idx), switched: 1'b1,
                                          refilled: r_pass2, no_runnable: 1'b0};
                        end else begin
                            n_res     = '{current_task: 3'(r_running), switched: 1'b0,
                                          refilled: r_pass2, no_runnable: 1'b0};
                        end
                    end else if (!r_pass2) begin
                        cmd_op  = CMD_REFILL;
                        n_pass2 = 1'b1;
                    end else begin
                        // every priority is zero: keep the current task
                        n_res = '{current_task: 3'(r_running), switched: 1'b0,
                                  refilled: 1'b1, no_runnable: 1'b1};
                    end
                end
            end
            ST_RESCAN: begin
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_running   <= '0;
            r_pass2     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_running   <= n_running;
            r_pass2     <= n_pass2;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if ((r_state == ST_EMIT) && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_running_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_running) < 32'(NUM_TASKS))
        else $error("running task index out of range");

    a_wave_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_ctl.valid |-> (r_state == ST_SCAN))
        else $error("scan wave finished outside scan state");

    a_none_refilled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.no_runnable) |-> o_out_data.refilled)
        else $error("no_runnable without refill");

    a_switch_runnable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.switched) |-> !o_out_data.no_runnable)
        else $error("switch flagged together with no_runnable");

    a_inject_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        inject |-> ((r_state == ST_IDLE) || (r_state == ST_RESCAN)))
        else $error("scan wave injected while another is in flight");
`endif

endmodule

`default_nettype wire
